// File: rtl/core/btd_pkg.sv
// ----------------------------------------------------------------------------
// btd_pkg
// Shared widths, register map and fixed constants of the beat transient
// detector.
// ----------------------------------------------------------------------------
package btd_pkg;

    localparam int LEVEL_W    = 8;
    localparam int TIME_W     = 32;
    localparam int DIST_W     = 10;
    localparam int BASE_W     = 12;
    localparam int Q4_SHIFT   = 4;
    localparam int EMA_SHIFT  = 3;   // EMA divisor 8
    localparam int REFRACT_W  = 16;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_LEVEL_FLOOR    = 2'd0;
    localparam logic [1:0] REG_MIN_RISE       = 2'd1;
    localparam logic [1:0] REG_MARGIN_DIVISOR = 2'd2;
    localparam logic [1:0] REG_REFRACTORY_MS  = 2'd3;

    localparam logic [LEVEL_W-1:0] MARGIN_DIVISOR_RST = 8'd1;

endpackage

// File: rtl/core/btd_if.sv
// ----------------------------------------------------------------------------
// btd_if
// Valid/ready channels of the beat transient detector: frame in, result out.
// ----------------------------------------------------------------------------
interface btd_in_if;
    logic                         valid;
    logic                         ready;
    logic [btd_pkg::LEVEL_W-1:0]  level;
    logic [btd_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, output level, output now_ms, input ready);
    modport sink   (input valid, input level, input now_ms, output ready);
endinterface

interface btd_out_if;
    logic                               valid;
    logic                               ready;
    logic                               beat;
    logic signed [btd_pkg::DIST_W-1:0]  distance;

    modport source (output valid, output beat, output distance, input ready);
    modport sink   (input valid, input beat, input distance, output ready);
endinterface

// File: rtl/core/beat_transient_detector_unit.sv
// ----------------------------------------------------------------------------
// beat_transient_detector_unit
// Per-frame onset detector: EMA baseline, adaptive threshold, refractory gate.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  i_in      in   valid/ready     level[7:0], now_ms[31:0]
//  o_out     out  valid/ready     beat, distance[9:0] signed
//  apb       in   psel/penable    paddr[3:0], pwdata -> 4 config registers
//
//  Each request passes through accept, 8 steps of the serial restoring
//  divider (baseline / margin_divisor, one quotient bit per cycle), and a final
//  step for threshold, beat and baseline update. The divider sets the rate.
//  Reset (synchronous, active low) resets config, sequencer and detector state.
//  A result waits in the output register; the next request is taken while it
//  waits, and only the final step stalls if the register is still full.
// ----------------------------------------------------------------------------
module beat_transient_detector_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    btd_in_if.sink                            i_in,
    btd_out_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [btd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [btd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [btd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CALC
    } t_state;

    localparam int LW = btd_pkg::LEVEL_W;
    localparam int BW = btd_pkg::BASE_W;
    localparam int DW = btd_pkg::DIST_W;
    localparam int TW = btd_pkg::TIME_W;
    localparam int SW = BW + 2;   // signed baseline update width

    // configuration
    logic [LW-1:0]                  r_level_floor;
    logic [LW-1:0]                  r_min_rise;
    logic [LW-1:0]                  r_margin_divisor;
    logic [btd_pkg::REFRACT_W-1:0]  r_refractory_ms;

    // detector state
    logic [BW-1:0]                  r_baseline_q4;
    logic [LW-1:0]                  r_previous_level;
    logic [TW-1:0]                  r_last_beat_ms;

    // sequencer and datapath
    t_state                         r_state;
    logic [2:0]                     r_step;
    logic [LW-1:0]                  r_level;
    logic [TW-1:0]                  r_now_ms;
    logic [LW-1:0]                  r_rem;
    logic [LW-1:0]                  r_quo;
    logic [LW-1:0]                  r_div;

    logic                           r_out_valid;
    logic                           r_out_beat;
    logic signed [DW-1:0]           r_out_distance;

    // APB
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            btd_pkg::REG_LEVEL_FLOOR:    prdata = {24'd0, r_level_floor};
            btd_pkg::REG_MIN_RISE:       prdata = {24'd0, r_min_rise};
            btd_pkg::REG_MARGIN_DIVISOR: prdata = {24'd0, r_margin_divisor};
            btd_pkg::REG_REFRACTORY_MS:  prdata = {16'd0, r_refractory_ms};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_floor    <= '0;
            r_min_rise       <= '0;
            r_margin_divisor <= btd_pkg::MARGIN_DIVISOR_RST;
            r_refractory_ms  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                btd_pkg::REG_LEVEL_FLOOR:    r_level_floor    <= pwdata[LW-1:0];
                btd_pkg::REG_MIN_RISE:       r_min_rise       <= pwdata[LW-1:0];
                btd_pkg::REG_MARGIN_DIVISOR: r_margin_divisor <= pwdata[LW-1:0];
                btd_pkg::REG_REFRACTORY_MS:
                    r_refractory_ms <= pwdata[btd_pkg::REFRACT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- divider step ----------------
    logic [LW:0]   div_trial;
    logic [LW:0]   div_sh;
    logic [LW-1:0] n_rem;
    logic [LW-1:0] n_quo;

    always_comb begin
        div_sh    = {r_rem, r_quo[LW-1]};
        div_trial = div_sh - {1'b0, r_div};
        if (!div_trial[LW]) begin
            n_rem = div_trial[LW-1:0];
            n_quo = {r_quo[LW-2:0], 1'b1};
        end else begin
            n_rem = div_sh[LW-1:0];
            n_quo = {r_quo[LW-2:0], 1'b0};
        end
    end

    // ---------------- threshold, beat, baseline ----------------
    logic [LW-1:0]        base_int;
    logic [LW-1:0]        margin;
    logic [LW:0]          bar_base;
    logic [LW:0]          bar_prev;
    logic [LW:0]          bar;
    logic signed [DW-1:0] bar_dist;
    logic                 rising;
    logic [TW-1:0]        elapsed;
    logic                 blocked;
    logic                 fire;
    logic signed [SW-1:0] delta;
    logic signed [SW-1:0] delta_adj;
    logic signed [SW-1:0] ema_step;
    logic signed [SW-1:0] base_sum;
    logic [BW-1:0]        n_baseline;

    always_comb begin
        base_int = r_baseline_q4[BW-1:btd_pkg::Q4_SHIFT];
        margin   = (r_quo < r_min_rise) ? r_min_rise : r_quo;
        bar_base = {1'b0, base_int} + {1'b0, margin};
        bar_prev = {1'b0, r_previous_level} + {1'b0, margin};
        bar      = (bar_prev > bar_base) ? bar_prev : bar_base;
        if ({1'b0, r_level_floor} > bar) begin
            bar = {1'b0, r_level_floor};
        end
        bar_dist = $signed({2'b00, r_level}) - $signed({1'b0, bar});
        rising   = !bar_dist[DW-1] && (bar_dist != '0);
        elapsed  = r_now_ms - r_last_beat_ms;
        blocked  = elapsed < {16'd0, r_refractory_ms};
        fire     = rising && !blocked;

        // EMA /8 truncating toward zero
        delta     = $signed({2'b00, r_level, 4'b0000}) - $signed({2'b00, r_baseline_q4});
        delta_adj = delta[SW-1] ? (delta + SW'(7)) : delta;
        ema_step  = delta_adj >>> btd_pkg::EMA_SHIFT;
        base_sum  = $signed({2'b00, r_baseline_q4}) + ema_step;
        n_baseline = base_sum[SW-1] ? '0 : base_sum[BW-1:0];
    end

    // ---------------- sequencer ----------------
    logic out_free;

    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.beat     = r_out_beat;
    assign o_out.distance = r_out_distance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_step           <= '0;
            r_out_valid      <= 1'b0;
            r_baseline_q4    <= '0;
            r_previous_level <= '0;
            r_last_beat_ms   <= '0;
        end else begin
            // in ST_CALC the output register is refilled below instead
            if (r_out_valid && o_out.ready && (r_state != ST_CALC)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_level  <= i_in.level;
                        r_now_ms <= i_in.now_ms;
                        r_rem    <= '0;
                        r_quo    <= r_baseline_q4[BW-1:btd_pkg::Q4_SHIFT];
                        r_div    <= (r_margin_divisor == '0) ? LW'(1) : r_margin_divisor;
                        r_step   <= '0;
                        r_state  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd7) begin
                        r_state <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    if (out_free) begin
                        r_out_valid      <= 1'b1;
                        r_out_beat       <= fire;
                        r_out_distance   <= bar_dist;
                        r_previous_level <= r_level;
                        r_baseline_q4    <= n_baseline;
                        if (fire) begin
                            r_last_beat_ms <= r_now_ms;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
